### sv/chs_pkg.sv
// ----------------------------------------------------------------------------
// Coalesced hash set package
// Command codes, field widths and register indexes shared by the block.
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int KEY_W   = 32;
	localparam int CMD_W   = 2;
	localparam int SLOTS_W = 11;
	localparam int COUNT_W = 11;
	localparam int RES_W   = 16;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	localparam logic REG_SLOTS = 1'b0;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 11'd13;

	// Magnitude of a two's complement key, as an unsigned word.
	function automatic logic [KEY_W-1:0] key_mag(input logic [KEY_W-1:0] k);
		key_mag = k[KEY_W-1] ? (~k + KEY_W'(1)) : k;
	endfunction

endpackage

### sv/coalesced_hash_set.sv
// ----------------------------------------------------------------------------
// Coalesced hash set
// Set of signed 32-bit keys in a table with coalesced chaining.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                          Content
// s_        in   s_tvalid s_tready s_tdata s_tuser  key word, command in tuser
// m_        out  m_tvalid m_tready m_tdata        success, full, count, empty
// apb       in   psel penable pwrite paddr pwdata  slots_in_use at address 0
//
// Every command but CMD_NONE first computes the home slot in the remainder
// unit and then walks the chain, each step a registered read of the slot
// memories. A remove then checks the rest of the chain, recomputing the home of
// each occupied slot in it, and finds the predecessor by a table scan when the
// walk did not give one. An add that fills the lowest free slot scans upward
// for the next one.
// After reset, and after every write of slots_in_use, a clearing pass over all
// CAPACITY slots empties the valid and link memories; no word is taken then.
// A new word is taken while an earlier result still waits on a stalled m_ side.
//
module coalesced_hash_set #(
	parameter int CAPACITY = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [chs_pkg::KEY_W-1:0]   s_tdata,   // [31:0] key
	input  logic [chs_pkg::CMD_W-1:0]   s_tuser,   // [1:0] cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] success, [1] table_full, [12:2] element_count, [13] set_empty, [15:14] zero
	output logic [chs_pkg::RES_W-1:0]   m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import chs_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int IW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] NO_LINK = IW'(CAPACITY);
	localparam logic [IW-1:0] CAP_I   = IW'(CAPACITY);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_WRD  = 4'd3;
	localparam logic [3:0] S_WCHK = 4'd4;
	localparam logic [3:0] S_ALNK = 4'd5;
	localparam logic [3:0] S_ADV  = 4'd6;
	localparam logic [3:0] S_ACHK = 4'd7;
	localparam logic [3:0] S_SRD  = 4'd8;
	localparam logic [3:0] S_SCHK = 4'd9;
	localparam logic [3:0] S_SDIV = 4'd10;
	localparam logic [3:0] S_PREV = 4'd11;
	localparam logic [3:0] S_PRD  = 4'd12;
	localparam logic [3:0] S_PCHK = 4'd13;
	localparam logic [3:0] S_UNL  = 4'd14;
	localparam logic [3:0] S_FREE = 4'd15;

	// Slot memories: keys (no reset), links and valid bits (cleared by a pass).
	logic [KEY_W-1:0] key_mem [CAPACITY];
	logic [IW-1:0]    link_mem [CAPACITY];
	logic             val_mem [CAPACITY];

	logic [3:0]         state_q;
	logic [SLOTS_W-1:0] cfg_q;
	logic [IW-1:0]      m_w;
	logic [AW-1:0]      clr_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [IW-1:0]      cur_q, prev_q, pp_q, pos_q, cur_link_q, pos_link_q, scan_q;
	logic [IW-1:0]      steps_q, ff_q, cnt_q;
	logic [KEY_W-1:0]   pos_key_q;
	logic               res_pend_q, res_ok_q, res_full_q;
	logic               m_tvalid_q;
	logic [RES_W-1:0]   m_tdata_q;

	logic [KEY_W-1:0]   key_rd;
	logic [IW-1:0]      link_rd;
	logic               val_rd;
	logic [IW-1:0]      rd_idx;

	logic               key_we, link_we, val_we;
	logic [IW-1:0]      key_wa, link_wa, val_wa;
	logic [KEY_W-1:0]   key_wd;
	logic [IW-1:0]      link_wd;
	logic               val_wd;

	logic               div_start, div_done;
	logic [KEY_W-1:0]   div_dvd;
	logic [IW-1:0]      div_rem;

	logic               cfg_wr, s_acc, holds_w, walk_more, home_free, ff_full;
	logic               res_free;
	logic [IW+COUNT_W-1:0] cnt_wide;

	// Effective slot count: zero counts as one, and it never exceeds the table.
	always_comb begin
		if (cfg_q == '0)
			m_w = IW'(1);
		else if (32'(cfg_q) > 32'(CAPACITY))
			m_w = CAP_I;
		else
			m_w = IW'(cfg_q);
	end

	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_SLOTS);
	assign pready    = 1'b1;
	assign prdata    = 32'(cfg_q);

	assign res_free  = !res_pend_q;
	assign s_tready  = (state_q == S_IDLE) && res_free;
	assign s_acc     = s_tvalid && s_tready;

	assign holds_w   = val_rd && (key_rd == key_q);
	assign walk_more = (link_rd != NO_LINK) && !holds_w && (steps_q < CAP_I);
	assign home_free = (steps_q == '0) && !val_rd;
	assign ff_full   = ff_q >= m_w;

	chs_mod #(.IW(IW)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (m_w),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = key_mag(s_tdata);
		if (state_q == S_IDLE && s_acc && s_tuser != CMD_NONE)
			div_start = 1'b1;
		if (state_q == S_SCHK && val_rd) begin
			div_start = 1'b1;
			div_dvd   = key_mag(key_rd);
		end
	end

	// Read address of the slot memories.
	always_comb begin
		unique case (state_q)
			S_SRD:   rd_idx = pos_q;
			S_PRD:   rd_idx = scan_q;
			S_ADV:   rd_idx = ff_q;
			default: rd_idx = cur_q;
		endcase
	end

	// Write ports of the slot memories.
	always_comb begin
		key_we  = 1'b0;
		key_wa  = cur_q;
		key_wd  = key_q;
		link_we = 1'b0;
		link_wa = cur_q;
		link_wd = NO_LINK;
		val_we  = 1'b0;
		val_wa  = cur_q;
		val_wd  = 1'b0;
		unique case (state_q)
			S_CLR: begin
				link_we = 1'b1;
				link_wa = IW'(clr_q);
				val_we  = 1'b1;
				val_wa  = IW'(clr_q);
			end
			S_WCHK: begin
				if (cmd_q == CMD_ADD && !walk_more && !holds_w) begin
					if (home_free) begin
						key_we  = 1'b1;
						link_we = 1'b1;
						val_we  = 1'b1;
						val_wd  = 1'b1;
					end else if (!ff_full) begin
						key_we  = 1'b1;
						key_wa  = ff_q;
						link_we = 1'b1;
						link_wa = ff_q;
						val_we  = 1'b1;
						val_wa  = ff_q;
						val_wd  = 1'b1;
					end
				end
			end
			S_ALNK: begin
				link_we = 1'b1;
				link_wd = ff_q;
			end
			S_SDIV: begin
				if (div_done && div_rem == cur_q) begin
					key_we = 1'b1;
					key_wd = pos_key_q;
				end
			end
			S_UNL: begin
				link_we = 1'b1;
				link_wa = prev_q;
				link_wd = cur_link_q;
			end
			S_FREE: begin
				link_we = 1'b1;
				val_we  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_wa[AW-1:0]] <= key_wd;
		key_rd <= key_mem[rd_idx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa[AW-1:0]] <= link_wd;
		link_rd <= link_mem[rd_idx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (val_we)
			val_mem[val_wa[AW-1:0]] <= val_wd;
		val_rd <= val_mem[rd_idx[AW-1:0]];
	end

	// Sequencer. A finished command parks its result in res_*_q until the
	// output register is free; no new word is taken while it waits there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			cfg_q      <= SLOTS_RESET;
			clr_q      <= '0;
			ff_q       <= '0;
			cnt_q      <= '0;
			res_pend_q <= 1'b0;
			res_ok_q   <= 1'b0;
			res_full_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_pend_q && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				res_pend_q <= 1'b0;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CAPACITY - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_acc) begin
						if (s_tuser == CMD_NONE) begin
							res_ok_q   <= 1'b0;
							res_full_q <= 1'b0;
							res_pend_q <= 1'b1;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (div_done) begin
						cur_q   <= div_rem;
						prev_q  <= NO_LINK;
						steps_q <= '0;
						state_q <= S_WRD;
					end
				end
				S_WRD: state_q <= S_WCHK;
				S_WCHK: begin
					cur_link_q <= link_rd;
					if (walk_more) begin
						prev_q  <= cur_q;
						cur_q   <= link_rd;
						steps_q <= steps_q + IW'(1);
						state_q <= S_WRD;
					end else begin
						res_ok_q   <= 1'b0;
						res_full_q <= 1'b0;
						state_q    <= S_IDLE;
						res_pend_q <= 1'b1;
						case (cmd_q)
							CMD_SEARCH: res_ok_q <= holds_w;
							CMD_ADD: begin
								if (!holds_w) begin
									if (home_free) begin
										res_ok_q <= 1'b1;
										cnt_q    <= cnt_q + IW'(1);
										if (cur_q == ff_q) begin
											ff_q       <= ff_q + IW'(1);
											state_q    <= S_ADV;
											res_pend_q <= 1'b0;
										end
									end else if (ff_full) begin
										res_full_q <= 1'b1;
									end else begin
										res_ok_q   <= 1'b1;
										cnt_q      <= cnt_q + IW'(1);
										state_q    <= S_ALNK;
										res_pend_q <= 1'b0;
									end
								end
							end
							default: begin
								if (holds_w) begin
									pos_q      <= link_rd;
									pp_q       <= cur_q;
									steps_q    <= '0;
									state_q    <= S_SRD;
									res_pend_q <= 1'b0;
								end
							end
						endcase
					end
				end
				S_ALNK: begin
					ff_q    <= ff_q + IW'(1);
					state_q <= S_ADV;
				end
				S_ADV: begin
					if (ff_full) begin
						state_q    <= S_IDLE;
						res_pend_q <= 1'b1;
					end else begin
						state_q <= S_ACHK;
					end
				end
				S_ACHK: begin
					if (val_rd) begin
						ff_q    <= ff_q + IW'(1);
						state_q <= S_ADV;
					end else begin
						state_q    <= S_IDLE;
						res_pend_q <= 1'b1;
					end
				end
				S_SRD: begin
					if (pos_q == NO_LINK || steps_q >= CAP_I)
						state_q <= S_PREV;
					else
						state_q <= S_SCHK;
				end
				S_SCHK: begin
					pos_key_q  <= key_rd;
					pos_link_q <= link_rd;
					if (val_rd) begin
						state_q <= S_SDIV;
					end else begin
						pp_q    <= pos_q;
						pos_q   <= link_rd;
						steps_q <= steps_q + IW'(1);
						state_q <= S_SRD;
					end
				end
				S_SDIV: begin
					if (div_done) begin
						steps_q <= steps_q + IW'(1);
						pos_q   <= pos_link_q;
						state_q <= S_SRD;
						if (div_rem == cur_q) begin
							// Key moves back into its home; continue from its old slot.
							prev_q     <= pp_q;
							cur_q      <= pos_q;
							cur_link_q <= pos_link_q;
							pp_q       <= pos_q;
						end else begin
							pp_q <= pos_q;
						end
					end
				end
				S_PREV: begin
					scan_q <= '0;
					if (prev_q != NO_LINK)
						state_q <= S_UNL;
					else
						state_q <= S_PRD;
				end
				S_PRD: begin
					if (scan_q >= m_w)
						state_q <= S_FREE;
					else
						state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (link_rd == cur_q) begin
						prev_q  <= scan_q;
						state_q <= S_UNL;
					end else begin
						scan_q  <= scan_q + IW'(1);
						state_q <= S_PRD;
					end
				end
				S_UNL: state_q <= S_FREE;
				S_FREE: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - IW'(1);
					if (cur_q < ff_q)
						ff_q <= cur_q;
					res_ok_q   <= 1'b1;
					res_full_q <= 1'b0;
					res_pend_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_wr) begin
				cfg_q   <= pwdata[SLOTS_W-1:0];
				state_q <= S_CLR;
				clr_q   <= '0;
				ff_q    <= '0;
				cnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_acc) begin
			cmd_q <= s_tuser;
			key_q <= s_tdata;
		end
	end

	assign cnt_wide = {{COUNT_W{1'b0}}, cnt_q};

	always_ff @(posedge clk) begin
		if (res_pend_q && (!m_tvalid_q || m_tready))
			m_tdata_q <= RES_W'({(cnt_q == '0), cnt_wide[COUNT_W-1:0], res_full_q, res_ok_q});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !s_tready)
		else $error("word taken during clearing pass");
	a_free_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (ff_q <= m_w))
		else $error("first free pointer beyond slots in use");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_I)
		else $error("element count beyond capacity");
	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> !m_tdata[0])
		else $error("refused add reported as success");
`endif

endmodule

### sv/chs_mod.sv
// ----------------------------------------------------------------------------
// Coalesced hash set remainder unit
// Restoring division, one dividend bit per cycle; gives the home slot.
// ----------------------------------------------------------------------------
module chs_mod #(
	parameter int IW = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [chs_pkg::KEY_W-1:0] dividend,
	input  logic [IW-1:0]            divisor,
	output logic                     done,
	output logic [IW-1:0]            remainder
);
	import chs_pkg::*;

	localparam int CNT_W = $clog2(KEY_W + 1);

	logic [IW-1:0]    rem_q;
	logic [KEY_W-1:0] dvd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [IW:0]      trial;

	assign trial = {rem_q, dvd_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= IW'(trial - {1'b0, divisor});
			else
				rem_q <= trial[IW-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
